// ===== rtl/core/slt_pkg.sv =====
// Shared operation codes, result status codes and result type for the sorted list table.
package slt_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 3;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_INSERT   = 3'd0;
    localparam kind_t KIND_DELETE   = 3'd1;
    localparam kind_t KIND_RETRIEVE = 3'd2;
    localparam kind_t KIND_REWIND   = 3'd3;
    localparam kind_t KIND_NEXT     = 3'd4;
    localparam kind_t KIND_CLEAR    = 3'd5;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   value;
    } res_t;

endpackage

// ===== rtl/core/slt_mem.sv =====
// Simple dual-port key store: one write port, one registered read port.
module slt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/slt_ctrl.sv =====
// Operation sequencer: binary search, shift passes and walk over the key store.
module slt_ctrl #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  slt_pkg::kind_t                      s_kind,
    input  logic [slt_pkg::DATA_W-1:0]          s_key,
    output logic                                res_valid,
    input  logic                                res_ready,
    output slt_pkg::res_t                       res,
    output logic [$clog2(CAPACITY+1)-1:0]       res_count,
    output logic                                mem_we,
    output logic [$clog2(CAPACITY)-1:0]         mem_waddr,
    output logic [((KEY_BITS < 32) ? KEY_BITS : 32)-1:0] mem_wdata,
    output logic                                mem_re,
    output logic [$clog2(CAPACITY)-1:0]         mem_raddr,
    input  logic [((KEY_BITS < 32) ? KEY_BITS : 32)-1:0] mem_rdata
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_NEXT,
        S_DONE
    } state_t;

    state_t                 state_reg;
    slt_pkg::kind_t         kind_reg;
    logic [KW-1:0]          key_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       walk_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic [CNT_W-1:0]       hi_reg;
    logic [AW-1:0]          mid_reg;
    logic [AW-1:0]          src_reg;
    logic                   eq_reg;
    slt_pkg::status_t       status_reg;
    logic [slt_pkg::DATA_W-1:0] value_reg;

    logic [CNT_W:0]         mid_sum;
    logic [AW-1:0]          mid;
    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       lo_p1;
    logic [CNT_W-1:0]       src_ext;
    logic [CNT_W-1:0]       src_p1;
    logic [CNT_W-1:0]       walk_pos;
    logic [CNT_W-1:0]       walk_pos_p1;
    logic [CNT_W-1:0]       walk_after;
    logic [slt_pkg::DATA_W-1:0] key_wide;
    logic [slt_pkg::DATA_W-1:0] rdata_wide;

    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[AW:1];
    assign cnt_m1      = count_reg - 1'b1;
    assign lo_p1       = lo_reg + 1'b1;
    assign src_ext     = CNT_W'(src_reg);
    assign src_p1      = src_ext + 1'b1;
    assign walk_pos    = (walk_reg >= count_reg) ? '0 : walk_reg;
    assign walk_pos_p1 = walk_pos + 1'b1;
    assign walk_after  = (walk_pos_p1 >= count_reg) ? '0 : walk_pos_p1;

    always_comb begin
        key_wide          = '0;
        key_wide[KW-1:0]  = key_reg;
        rdata_wide        = '0;
        rdata_wide[KW-1:0] = mem_rdata;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.value     = value_reg;
    assign res_count     = count_reg;

    // memory port steering
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = mid;
        mem_we    = 1'b0;
        mem_waddr = src_p1[AW-1:0];
        mem_wdata = mem_rdata;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_kind == slt_pkg::KIND_NEXT && count_reg != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = walk_pos[AW-1:0];
                end
            end
            S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = mid;
                end else if (kind_reg == slt_pkg::KIND_INSERT && lo_reg < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_m1[AW-1:0];
                end else if (kind_reg == slt_pkg::KIND_DELETE && eq_reg
                             && lo_p1 < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = lo_p1[AW-1:0];
                end
            end
            S_INS_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = src_p1[AW-1:0];
                mem_wdata = mem_rdata;
                if (src_ext > lo_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg - 1'b1;
                end
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[AW-1:0];
                mem_wdata = key_reg;
            end
            S_DEL_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = src_reg - 1'b1;
                mem_wdata = mem_rdata;
                if (src_p1 < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = src_p1[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            walk_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg   <= s_kind;
                        key_reg    <= s_key[KW-1:0];
                        lo_reg     <= '0;
                        hi_reg     <= count_reg;
                        eq_reg     <= 1'b0;
                        status_reg <= slt_pkg::STATUS_OK;
                        value_reg  <= '0;
                        state_reg  <= S_DONE;
                        case (s_kind)
                            slt_pkg::KIND_INSERT: begin
                                if (count_reg == CAP_CNT) begin
                                    status_reg <= slt_pkg::STATUS_FULL;
                                end else begin
                                    state_reg <= S_SRCH;
                                end
                            end
                            slt_pkg::KIND_DELETE, slt_pkg::KIND_RETRIEVE: begin
                                state_reg <= S_SRCH;
                            end
                            slt_pkg::KIND_REWIND: begin
                                walk_reg <= '0;
                            end
                            slt_pkg::KIND_NEXT: begin
                                if (count_reg == '0) begin
                                    status_reg <= slt_pkg::STATUS_EMPTY;
                                    walk_reg   <= '0;
                                end else begin
                                    walk_reg  <= walk_after;
                                    state_reg <= S_NEXT;
                                end
                            end
                            slt_pkg::KIND_CLEAR: begin
                                count_reg <= '0;
                                walk_reg  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end else begin
                        // lo_reg now holds the lower bound
                        state_reg <= S_DONE;
                        case (kind_reg)
                            slt_pkg::KIND_INSERT: begin
                                if (lo_reg < count_reg) begin
                                    src_reg   <= cnt_m1[AW-1:0];
                                    state_reg <= S_INS_SHIFT;
                                end else begin
                                    state_reg <= S_INS_PUT;
                                end
                            end
                            slt_pkg::KIND_DELETE: begin
                                if (!eq_reg) begin
                                    status_reg <= slt_pkg::STATUS_NOT_FOUND;
                                end else if (lo_p1 < count_reg) begin
                                    src_reg   <= lo_p1[AW-1:0];
                                    state_reg <= S_DEL_SHIFT;
                                end else begin
                                    count_reg <= cnt_m1;
                                end
                            end
                            default: begin
                                if (eq_reg) begin
                                    value_reg <= key_wide;
                                end else begin
                                    status_reg <= slt_pkg::STATUS_NOT_FOUND;
                                end
                            end
                        endcase
                    end
                end
                S_CMP: begin
                    if (mem_rdata < key_reg) begin
                        lo_reg <= CNT_W'(mid_reg) + 1'b1;
                    end else begin
                        hi_reg <= CNT_W'(mid_reg);
                        eq_reg <= (mem_rdata == key_reg);
                    end
                    state_reg <= S_SRCH;
                end
                S_INS_SHIFT: begin
                    if (src_ext > lo_reg) begin
                        src_reg <= src_reg - 1'b1;
                    end else begin
                        state_reg <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_DEL_SHIFT: begin
                    if (src_p1 < count_reg) begin
                        src_reg <= src_p1[AW-1:0];
                    end else begin
                        count_reg <= cnt_m1;
                        state_reg <= S_DONE;
                    end
                end
                S_NEXT: begin
                    value_reg <= rdata_wide;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("key count above capacity");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re && mem_waddr == mem_raddr))
        else $error("read and write hit the same entry");

    a_full_only_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && status_reg == slt_pkg::STATUS_FULL) |-> (count_reg == CAP_CNT))
        else $error("full reported below capacity");

    // the last delete move also drops the count
    a_shift_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_SHIFT || (state_reg == S_DEL_SHIFT && src_p1 < count_reg))
        |=> $stable(count_reg))
        else $error("count moved during a shift pass");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_PUT) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not add one key");

endmodule

// ===== rtl/core/sorted_list_table.sv =====
// Sorted key table top level: key store, operation sequencer and result register.
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  input   | s_valid s_ready s_kind s_key       | in
//  result  | m_valid m_ready m_status m_value   | out
//          | m_count                            |
//
// One operation at a time. Rewind, clear, refused insert and unused kinds go
// straight from idle to the result; next on a non-empty table reads one key first.
// Insert, delete and retrieve first run a binary search, each step a read and a
// compare (up to clog2(CAPACITY+1) steps on the single read port); insert then
// moves one key per cycle and writes the new key, delete moves one key per cycle.
// Reset empties the table at once; no sweep of the store is needed.
// A stalled result sits in the output register while the next beat is taken.
module sorted_list_table #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [slt_pkg::KIND_W-1:0]          s_kind,
    input  logic [slt_pkg::DATA_W-1:0]          s_key,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [slt_pkg::DATA_W-1:0]          m_value,
    output logic [$clog2(CAPACITY+1)-1:0]       m_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;

    logic                res_valid;
    logic                res_ready;
    slt_pkg::res_t       res;
    logic [CNT_W-1:0]    res_count;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [KW-1:0]       mem_rdata;

    logic                m_valid_reg;
    slt_pkg::res_t       res_reg;
    logic [CNT_W-1:0]    count_reg;

    slt_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_key     (s_key),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .res_count (res_count),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    slt_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (KW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // load a new result when the register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg   <= res;
            count_reg <= res_count;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = res_reg.status;
    assign m_value  = res_reg.value;
    assign m_count  = count_reg;

endmodule
